### design/aarm_pkg.sv
// Shared constants, types and arithmetic helpers for the axis-angle rotation matrix block.
`default_nettype none

package aarm_pkg;

    // Port field widths
    localparam int ANGLE_W = 24;
    localparam int AXIS_W  = 16;
    localparam int ENT_W   = 18;

    // Angle reduction, in 1/128 degree units
    localparam int FULL_TURN    = 46080;
    localparam int QUARTER_TURN = 11520;
    localparam int TURN_OFFSET  = 183 * FULL_TURN;
    localparam int RED_W        = 25;
    localparam int RECIP_M      = 23860930;
    localparam int RECIP_SH     = 40;
    localparam int TURN_CNT_W   = 9;
    localparam int REM_W        = 16;
    localparam int ARG_W        = 14;
    localparam int ARG_SH       = 15;

    // CORDIC
    localparam int CORDIC_STEPS     = 20;
    localparam int CORDIC_PER_STAGE = 2;
    localparam int CORDIC_STAGES    = CORDIC_STEPS / CORDIC_PER_STAGE;
    localparam int CX_W             = 33;
    localparam int CZ_W             = 31;
    localparam int CORDIC_X0        = 652032875;
    localparam int ATAN_W           = 28;

    localparam logic [ATAN_W-1:0] ATAN_TAB [CORDIC_STEPS] = '{
        28'd188743680, 28'd111421900, 28'd58872272, 28'd29884485, 28'd15000234,
        28'd7507429,   28'd3754631,   28'd1877430,  28'd938729,   28'd469366,
        28'd234683,    28'd117342,    28'd58671,    28'd29336,    28'd14668,
        28'd7334,      28'd3667,      28'd1834,     28'd917,      28'd458
    };

    // Axis normalization
    localparam int LEN_W          = 32;
    localparam int ROOT_W         = 32;
    localparam int SQRT_PER_STAGE = 4;
    localparam int SQRT_STAGES    = ROOT_W / SQRT_PER_STAGE;
    localparam int DIV_PER_STAGE  = 4;
    localparam int DIV_STAGES     = ROOT_W / DIV_PER_STAGE;
    localparam int DIV_PRE_SH     = 14;
    localparam int UNIT_W         = 32;

    // Latency of both front paths, in register stages
    localparam int CORE_LAT = 1 + SQRT_STAGES + DIV_STAGES;
    localparam int ANG_PAD  = CORE_LAT - (3 + CORDIC_STAGES + 1);

    // Matrix arithmetic
    localparam int ONE_Q30    = 1 << 30;
    localparam int Q_SH       = 30;
    localparam int MUL_W      = 34;
    localparam int PROD_W     = 36;
    localparam int OUT_SH     = 14;
    localparam int ROUND_HALF = 1 << (OUT_SH - 1);
    localparam int ENT_ONE    = 65536;

    typedef logic signed [CX_W-1:0]   cx_t;
    typedef logic signed [CZ_W-1:0]   cz_t;
    typedef logic signed [UNIT_W-1:0] unit_t;
    typedef logic signed [MUL_W-1:0]  mul_t;
    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic signed [ENT_W-1:0]  ent_t;

    typedef enum logic [1:0] {QUAD_0, QUAD_1, QUAD_2, QUAD_3} quad_t;

    typedef struct packed {
        cx_t x;
        cx_t y;
        cz_t z;
    } cordic_vec_t;

    function automatic cordic_vec_t cordic_iter(cordic_vec_t v, int unsigned i);
        cx_t         dx;
        cx_t         dy;
        cz_t         da;
        cordic_vec_t o;
        dx = v.y >>> i;
        dy = v.x >>> i;
        da = cz_t'(ATAN_TAB[i]);
        if (!v.z[CZ_W-1])
        begin
            o.x = v.x - dx;
            o.y = v.y + dy;
            o.z = v.z - da;
        end
        else
        begin
            o.x = v.x + dx;
            o.y = v.y - dy;
            o.z = v.z + da;
        end
        return o;
    endfunction

    // Q30 product, floored
    function automatic prod_t qmul(mul_t a, mul_t b);
        logic signed [2*MUL_W-1:0] p;
        p = a * b;
        return PROD_W'(p >>> Q_SH);
    endfunction

    // Round Q30 to Q1.16 and clamp to plus or minus one
    function automatic ent_t to_q16(prod_t v);
        logic signed [PROD_W:0] r;
        r = ((PROD_W+1)'(v) + (PROD_W+1)'(ROUND_HALF)) >>> OUT_SH;
        if (r > (PROD_W+1)'(ENT_ONE))
        begin
            r = (PROD_W+1)'(ENT_ONE);
        end
        else if (r < -(PROD_W+1)'(ENT_ONE))
        begin
            r = -(PROD_W+1)'(ENT_ONE);
        end
        return ENT_W'(r);
    endfunction

endpackage

`default_nettype wire

### design/aarm_in_if.sv
// Input channel: angle and axis with valid/ready handshake.
`default_nettype none

interface aarm_in_if;
    logic                                valid;
    logic                                ready;
    logic signed [aarm_pkg::ANGLE_W-1:0] angle_deg;
    logic signed [aarm_pkg::AXIS_W-1:0]  axis_x;
    logic signed [aarm_pkg::AXIS_W-1:0]  axis_y;
    logic signed [aarm_pkg::AXIS_W-1:0]  axis_z;

    modport source (output valid, angle_deg, axis_x, axis_y, axis_z, input ready);
    modport sink   (input valid, angle_deg, axis_x, axis_y, axis_z, output ready);
endinterface

`default_nettype wire

### design/aarm_out_if.sv
// Output channel: nine matrix entries and the zero-axis flag with valid/ready handshake.
`default_nettype none

interface aarm_out_if;
    logic                              valid;
    logic                              ready;
    logic signed [aarm_pkg::ENT_W-1:0] m00;
    logic signed [aarm_pkg::ENT_W-1:0] m01;
    logic signed [aarm_pkg::ENT_W-1:0] m02;
    logic signed [aarm_pkg::ENT_W-1:0] m10;
    logic signed [aarm_pkg::ENT_W-1:0] m11;
    logic signed [aarm_pkg::ENT_W-1:0] m12;
    logic signed [aarm_pkg::ENT_W-1:0] m20;
    logic signed [aarm_pkg::ENT_W-1:0] m21;
    logic signed [aarm_pkg::ENT_W-1:0] m22;
    logic                              axis_zero;

    modport source (output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22, axis_zero,
                    input ready);
    modport sink   (input valid, m00, m01, m02, m10, m11, m12, m20, m21, m22, axis_zero,
                    output ready);
endinterface

`default_nettype wire

### design/aarm_cordic.sv
// Angle reduction and pipelined CORDIC giving cosine and sine in Q30.
`default_nettype none

module aarm_cordic (
    input  logic                                clk,
    input  logic                                en,
    input  logic signed [aarm_pkg::ANGLE_W-1:0] angle_deg,
    output aarm_pkg::cx_t                       cos_q,
    output aarm_pkg::cx_t                       sin_q
);

    logic signed [aarm_pkg::RED_W:0]        u_sum;
    logic [aarm_pkg::RED_W-1:0]             u_reg;
    logic [aarm_pkg::RED_W-1:0]             u1_reg;
    logic [2*aarm_pkg::RED_W-1:0]           prod;
    logic [aarm_pkg::TURN_CNT_W-1:0]        turns_reg;
    logic [aarm_pkg::RED_W-1:0]             rem_full;
    logic [aarm_pkg::REM_W-1:0]             rem;
    aarm_pkg::quad_t                        quad_next;
    logic [aarm_pkg::REM_W-1:0]             arg_full;
    logic [aarm_pkg::ARG_W-1:0]             arg;

    aarm_pkg::cordic_vec_t cv_reg   [aarm_pkg::CORDIC_STAGES+1];
    aarm_pkg::cordic_vec_t cv_next  [aarm_pkg::CORDIC_STAGES];
    aarm_pkg::quad_t       qd_reg   [aarm_pkg::CORDIC_STAGES+1];
    aarm_pkg::cx_t         c_next;
    aarm_pkg::cx_t         s_next;
    aarm_pkg::cx_t         c_reg    [aarm_pkg::ANG_PAD+1];
    aarm_pkg::cx_t         s_reg    [aarm_pkg::ANG_PAD+1];

    // Shift the angle to a non-negative value with the same residue
    assign u_sum = (aarm_pkg::RED_W+1)'(angle_deg)
                 + (aarm_pkg::RED_W+1)'(aarm_pkg::TURN_OFFSET);
    assign prod  = {{aarm_pkg::RED_W{1'b0}}, u_reg}
                 * (2*aarm_pkg::RED_W)'(aarm_pkg::RECIP_M);

    assign rem_full = u1_reg - (aarm_pkg::RED_W'(turns_reg)
                              * aarm_pkg::RED_W'(aarm_pkg::FULL_TURN));
    assign rem      = rem_full[aarm_pkg::REM_W-1:0];

    always_comb
    begin
        if (rem >= aarm_pkg::REM_W'(3 * aarm_pkg::QUARTER_TURN))
        begin
            quad_next = aarm_pkg::QUAD_3;
            arg_full  = rem - aarm_pkg::REM_W'(3 * aarm_pkg::QUARTER_TURN);
        end
        else if (rem >= aarm_pkg::REM_W'(2 * aarm_pkg::QUARTER_TURN))
        begin
            quad_next = aarm_pkg::QUAD_2;
            arg_full  = rem - aarm_pkg::REM_W'(2 * aarm_pkg::QUARTER_TURN);
        end
        else if (rem >= aarm_pkg::REM_W'(aarm_pkg::QUARTER_TURN))
        begin
            quad_next = aarm_pkg::QUAD_1;
            arg_full  = rem - aarm_pkg::REM_W'(aarm_pkg::QUARTER_TURN);
        end
        else
        begin
            quad_next = aarm_pkg::QUAD_0;
            arg_full  = rem;
        end
    end

    assign arg = arg_full[aarm_pkg::ARG_W-1:0];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            u_reg       <= u_sum[aarm_pkg::RED_W-1:0];
            u1_reg      <= u_reg;
            turns_reg   <= prod[aarm_pkg::RECIP_SH +: aarm_pkg::TURN_CNT_W];
            cv_reg[0].x <= aarm_pkg::cx_t'(aarm_pkg::CORDIC_X0);
            cv_reg[0].y <= '0;
            cv_reg[0].z <= aarm_pkg::cz_t'({arg, {aarm_pkg::ARG_SH{1'b0}}});
            qd_reg[0]   <= quad_next;
        end
    end

    for (genvar k = 0; k < aarm_pkg::CORDIC_STAGES; k++)
    begin : g_cordic
        always_comb
        begin
            aarm_pkg::cordic_vec_t v;
            v = cv_reg[k];
            for (int j = 0; j < aarm_pkg::CORDIC_PER_STAGE; j++)
            begin
                v = aarm_pkg::cordic_iter(v, k * aarm_pkg::CORDIC_PER_STAGE + j);
            end
            cv_next[k] = v;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                cv_reg[k+1] <= cv_next[k];
                qd_reg[k+1] <= qd_reg[k];
            end
        end
    end

    // Map the first-quadrant result onto the full circle
    always_comb
    begin
        unique case (qd_reg[aarm_pkg::CORDIC_STAGES])
            aarm_pkg::QUAD_0:
            begin
                c_next = cv_reg[aarm_pkg::CORDIC_STAGES].x;
                s_next = cv_reg[aarm_pkg::CORDIC_STAGES].y;
            end
            aarm_pkg::QUAD_1:
            begin
                c_next = -cv_reg[aarm_pkg::CORDIC_STAGES].y;
                s_next = cv_reg[aarm_pkg::CORDIC_STAGES].x;
            end
            aarm_pkg::QUAD_2:
            begin
                c_next = -cv_reg[aarm_pkg::CORDIC_STAGES].x;
                s_next = -cv_reg[aarm_pkg::CORDIC_STAGES].y;
            end
            default:
            begin
                c_next = cv_reg[aarm_pkg::CORDIC_STAGES].y;
                s_next = -cv_reg[aarm_pkg::CORDIC_STAGES].x;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c_reg[0] <= c_next;
            s_reg[0] <= s_next;
        end
    end

    // Delay to line up with the axis normalization
    for (genvar p = 0; p < aarm_pkg::ANG_PAD; p++)
    begin : g_pad
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                c_reg[p+1] <= c_reg[p];
                s_reg[p+1] <= s_reg[p];
            end
        end
    end

    assign cos_q = c_reg[aarm_pkg::ANG_PAD];
    assign sin_q = s_reg[aarm_pkg::ANG_PAD];

endmodule

`default_nettype wire

### design/aarm_norm.sv
// Axis normalization: pipelined integer square root and three pipelined dividers.
`default_nettype none

module aarm_norm (
    input  logic                               clk,
    input  logic                               en,
    input  logic signed [aarm_pkg::AXIS_W-1:0] axis_x,
    input  logic signed [aarm_pkg::AXIS_W-1:0] axis_y,
    input  logic signed [aarm_pkg::AXIS_W-1:0] axis_z,
    output aarm_pkg::unit_t                    ux,
    output aarm_pkg::unit_t                    uy,
    output aarm_pkg::unit_t                    uz,
    output logic                               zero
);

    localparam int SIDE_STAGES = aarm_pkg::SQRT_STAGES + aarm_pkg::DIV_STAGES;

    typedef struct packed {
        logic [aarm_pkg::LEN_W-1:0]  src;
        logic [aarm_pkg::ROOT_W+2:0] rem;
        logic [aarm_pkg::ROOT_W-1:0] root;
    } sqrt_t;

    typedef struct packed {
        logic [2:0]                          neg;
        logic [2:0][aarm_pkg::AXIS_W-1:0]    mag;
        logic                                zero;
    } side_t;

    typedef struct packed {
        logic [aarm_pkg::ROOT_W-1:0] rem;
        logic [aarm_pkg::ROOT_W-1:0] quo;
    } lane_t;

    typedef struct packed {
        logic [aarm_pkg::ROOT_W-1:0] root;
        lane_t [2:0]                 lane;
    } div_t;

    function automatic sqrt_t sqrt_iter(sqrt_t v);
        logic [aarm_pkg::ROOT_W+2:0] r2;
        logic [aarm_pkg::ROOT_W+2:0] trial;
        sqrt_t                       o;
        r2     = {v.rem[aarm_pkg::ROOT_W:0], v.src[aarm_pkg::LEN_W-1 -: 2]};
        trial  = {1'b0, v.root, 2'b01};
        o.src  = v.src << 2;
        if (r2 >= trial)
        begin
            o.rem  = r2 - trial;
            o.root = {v.root[aarm_pkg::ROOT_W-2:0], 1'b1};
        end
        else
        begin
            o.rem  = r2;
            o.root = {v.root[aarm_pkg::ROOT_W-2:0], 1'b0};
        end
        return o;
    endfunction

    function automatic lane_t div_iter(lane_t v, logic [aarm_pkg::ROOT_W-1:0] d);
        logic [aarm_pkg::ROOT_W:0] r2;
        logic [aarm_pkg::ROOT_W:0] diff;
        lane_t                     o;
        r2   = {v.rem, 1'b0};
        diff = r2 - {1'b0, d};
        if (r2 >= {1'b0, d})
        begin
            o.rem = diff[aarm_pkg::ROOT_W-1:0];
            o.quo = {v.quo[aarm_pkg::ROOT_W-2:0], 1'b1};
        end
        else
        begin
            o.rem = r2[aarm_pkg::ROOT_W-1:0];
            o.quo = {v.quo[aarm_pkg::ROOT_W-2:0], 1'b0};
        end
        return o;
    endfunction

    function automatic aarm_pkg::unit_t to_unit(logic [aarm_pkg::ROOT_W-1:0] q, logic neg);
        logic [aarm_pkg::ROOT_W-1:0] m;
        m = (q > aarm_pkg::ROOT_W'(aarm_pkg::ONE_Q30)) ? aarm_pkg::ROOT_W'(aarm_pkg::ONE_Q30) : q;
        return neg ? -aarm_pkg::unit_t'(m) : aarm_pkg::unit_t'(m);
    endfunction

    function automatic logic [aarm_pkg::AXIS_W-1:0] mag_of(logic signed [aarm_pkg::AXIS_W-1:0] v);
        return v[aarm_pkg::AXIS_W-1] ? aarm_pkg::AXIS_W'(-v) : aarm_pkg::AXIS_W'(v);
    endfunction

    logic signed [2*aarm_pkg::AXIS_W-1:0] sq_x;
    logic signed [2*aarm_pkg::AXIS_W-1:0] sq_y;
    logic signed [2*aarm_pkg::AXIS_W-1:0] sq_z;
    logic [aarm_pkg::LEN_W-1:0]           len2;
    side_t                                side_next;
    sqrt_t                                sq_next;

    sqrt_t sq_reg   [aarm_pkg::SQRT_STAGES+1];
    sqrt_t sq_step  [aarm_pkg::SQRT_STAGES];
    side_t side_reg [SIDE_STAGES+1];
    div_t  div_in;
    div_t  div_src  [aarm_pkg::DIV_STAGES];
    div_t  div_reg  [1:aarm_pkg::DIV_STAGES];
    div_t  div_step [aarm_pkg::DIV_STAGES];

    assign sq_x = axis_x * axis_x;
    assign sq_y = axis_y * axis_y;
    assign sq_z = axis_z * axis_z;
    assign len2 = aarm_pkg::LEN_W'(sq_x) + aarm_pkg::LEN_W'(sq_y) + aarm_pkg::LEN_W'(sq_z);

    always_comb
    begin
        side_next.neg  = {axis_z[aarm_pkg::AXIS_W-1], axis_y[aarm_pkg::AXIS_W-1],
                          axis_x[aarm_pkg::AXIS_W-1]};
        side_next.mag  = {mag_of(axis_z), mag_of(axis_y), mag_of(axis_x)};
        side_next.zero = (len2 == '0);
        sq_next.src    = len2;
        sq_next.rem    = '0;
        sq_next.root   = '0;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq_reg[0]   <= sq_next;
            side_reg[0] <= side_next;
        end
    end

    for (genvar k = 0; k < SIDE_STAGES; k++)
    begin : g_side
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                side_reg[k+1] <= side_reg[k];
            end
        end
    end

    // Square root of len2 * 2^32, two radicand bits per step
    for (genvar k = 0; k < aarm_pkg::SQRT_STAGES; k++)
    begin : g_sqrt
        always_comb
        begin
            sqrt_t v;
            v = sq_reg[k];
            for (int j = 0; j < aarm_pkg::SQRT_PER_STAGE; j++)
            begin
                v = sqrt_iter(v);
            end
            sq_step[k] = v;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                sq_reg[k+1] <= sq_step[k];
            end
        end
    end

    // Start each divider with the magnitude times 2^46 already reduced by 2^32
    always_comb
    begin
        div_in.root = sq_reg[aarm_pkg::SQRT_STAGES].root;
        for (int l = 0; l < 3; l++)
        begin
            div_in.lane[l].rem = aarm_pkg::ROOT_W'(side_reg[aarm_pkg::SQRT_STAGES].mag[l])
                               << aarm_pkg::DIV_PRE_SH;
            div_in.lane[l].quo = '0;
        end
    end

    for (genvar k = 0; k < aarm_pkg::DIV_STAGES; k++)
    begin : g_div
        if (k == 0)
        begin : g_head
            assign div_src[k] = div_in;
        end
        else
        begin : g_body
            assign div_src[k] = div_reg[k];
        end

        always_comb
        begin
            div_t v;
            v = div_src[k];
            for (int j = 0; j < aarm_pkg::DIV_PER_STAGE; j++)
            begin
                for (int l = 0; l < 3; l++)
                begin
                    v.lane[l] = div_iter(v.lane[l], v.root);
                end
            end
            div_step[k] = v;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                div_reg[k+1] <= div_step[k];
            end
        end
    end

    assign ux   = to_unit(div_reg[aarm_pkg::DIV_STAGES].lane[0].quo, side_reg[SIDE_STAGES].neg[0]);
    assign uy   = to_unit(div_reg[aarm_pkg::DIV_STAGES].lane[1].quo, side_reg[SIDE_STAGES].neg[1]);
    assign uz   = to_unit(div_reg[aarm_pkg::DIV_STAGES].lane[2].quo, side_reg[SIDE_STAGES].neg[2]);
    assign zero = side_reg[SIDE_STAGES].zero;

endmodule

`default_nettype wire

### design/axis_angle_rotation_matrix.sv
// Top level: axis-angle to 3x3 rotation matrix, fully pipelined.
// Throughput: one item per cycle while the output does not stall.
// Data path: the 17-stage square root and divider pipeline, which runs beside the angle
// reduction and 10-stage CORDIC, then three matrix stages.
// A stall at the output freezes the whole pipeline; input ready follows output space.
// Reset clears only the valid bits; data registers are not reset.
`default_nettype none

module axis_angle_rotation_matrix (
    input  logic       clk,
    input  logic       rst_n,
    aarm_in_if.sink    item,
    aarm_out_if.source result
);

    localparam int XX = 0;
    localparam int YY = 1;
    localparam int ZZ = 2;
    localparam int XY = 3;
    localparam int XZ = 4;
    localparam int YZ = 5;
    localparam int UX = 0;
    localparam int UY = 1;
    localparam int UZ = 2;

    logic                  en;
    logic [aarm_pkg::CORE_LAT-1:0] vld_reg;
    logic                  p1_vld_reg;
    logic                  p2_vld_reg;
    logic                  out_vld_reg;

    aarm_pkg::cx_t         cos_q;
    aarm_pkg::cx_t         sin_q;
    aarm_pkg::unit_t       ux;
    aarm_pkg::unit_t       uy;
    aarm_pkg::unit_t       uz;
    logic                  zero;

    aarm_pkg::prod_t       uu_next [6];
    aarm_pkg::prod_t       us_next [3];
    aarm_pkg::prod_t       uu_reg  [6];
    aarm_pkg::prod_t       us1_reg [3];
    aarm_pkg::cx_t         c1_reg;
    aarm_pkg::mul_t        t1_reg;
    logic                  z1_reg;

    aarm_pkg::prod_t       pp_next [6];
    aarm_pkg::prod_t       pp_reg  [6];
    aarm_pkg::prod_t       us2_reg [3];
    aarm_pkg::prod_t       c2;
    aarm_pkg::cx_t         c2_reg;
    logic                  z2_reg;

    aarm_pkg::ent_t        m_next [9];
    aarm_pkg::ent_t        m_reg  [9];
    logic                  zero_reg;

    // Advance when the output register is free or being taken
    assign en         = !out_vld_reg || result.ready;
    assign item.ready = en;

    aarm_cordic u_cordic (
        .clk       (clk),
        .en        (en),
        .angle_deg (item.angle_deg),
        .cos_q     (cos_q),
        .sin_q     (sin_q)
    );

    aarm_norm u_norm (
        .clk    (clk),
        .en     (en),
        .axis_x (item.axis_x),
        .axis_y (item.axis_y),
        .axis_z (item.axis_z),
        .ux     (ux),
        .uy     (uy),
        .uz     (uz),
        .zero   (zero)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg     <= '0;
            p1_vld_reg  <= 1'b0;
            p2_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg     <= {vld_reg[aarm_pkg::CORE_LAT-2:0], item.valid};
            p1_vld_reg  <= vld_reg[aarm_pkg::CORE_LAT-1];
            p2_vld_reg  <= p1_vld_reg;
            out_vld_reg <= p2_vld_reg;
        end
    end

    // First products: axis outer product and axis times sine
    always_comb
    begin
        uu_next[XX] = aarm_pkg::qmul(aarm_pkg::MUL_W'(ux), aarm_pkg::MUL_W'(ux));
        uu_next[YY] = aarm_pkg::qmul(aarm_pkg::MUL_W'(uy), aarm_pkg::MUL_W'(uy));
        uu_next[ZZ] = aarm_pkg::qmul(aarm_pkg::MUL_W'(uz), aarm_pkg::MUL_W'(uz));
        uu_next[XY] = aarm_pkg::qmul(aarm_pkg::MUL_W'(ux), aarm_pkg::MUL_W'(uy));
        uu_next[XZ] = aarm_pkg::qmul(aarm_pkg::MUL_W'(ux), aarm_pkg::MUL_W'(uz));
        uu_next[YZ] = aarm_pkg::qmul(aarm_pkg::MUL_W'(uy), aarm_pkg::MUL_W'(uz));
        us_next[UX] = aarm_pkg::qmul(aarm_pkg::MUL_W'(ux), aarm_pkg::MUL_W'(sin_q));
        us_next[UY] = aarm_pkg::qmul(aarm_pkg::MUL_W'(uy), aarm_pkg::MUL_W'(sin_q));
        us_next[UZ] = aarm_pkg::qmul(aarm_pkg::MUL_W'(uz), aarm_pkg::MUL_W'(sin_q));
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            uu_reg  <= uu_next;
            us1_reg <= us_next;
            c1_reg  <= cos_q;
            t1_reg  <= aarm_pkg::MUL_W'(aarm_pkg::ONE_Q30) - aarm_pkg::MUL_W'(cos_q);
            z1_reg  <= zero;
        end
    end

    // Second products: scale the outer product by one minus cosine
    always_comb
    begin
        for (int i = 0; i < 6; i++)
        begin
            pp_next[i] = aarm_pkg::qmul(aarm_pkg::MUL_W'(uu_reg[i]), t1_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pp_reg  <= pp_next;
            us2_reg <= us1_reg;
            c2_reg  <= c1_reg;
            z2_reg  <= z1_reg;
        end
    end

    assign c2 = aarm_pkg::PROD_W'(c2_reg);

    always_comb
    begin
        m_next[0] = aarm_pkg::to_q16(c2 + pp_reg[XX]);
        m_next[1] = aarm_pkg::to_q16(pp_reg[XY] - us2_reg[UZ]);
        m_next[2] = aarm_pkg::to_q16(pp_reg[XZ] + us2_reg[UY]);
        m_next[3] = aarm_pkg::to_q16(pp_reg[XY] + us2_reg[UZ]);
        m_next[4] = aarm_pkg::to_q16(c2 + pp_reg[YY]);
        m_next[5] = aarm_pkg::to_q16(pp_reg[YZ] - us2_reg[UX]);
        m_next[6] = aarm_pkg::to_q16(pp_reg[XZ] - us2_reg[UY]);
        m_next[7] = aarm_pkg::to_q16(pp_reg[YZ] + us2_reg[UX]);
        m_next[8] = aarm_pkg::to_q16(c2 + pp_reg[ZZ]);
        // Zero-length axis: drop the computed matrix, give identity
        if (z2_reg)
        begin
            for (int i = 0; i < 9; i++)
            begin
                m_next[i] = (i % 4 == 0) ? aarm_pkg::ENT_W'(aarm_pkg::ENT_ONE) : '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_reg    <= m_next;
            zero_reg <= z2_reg;
        end
    end

    assign result.valid     = out_vld_reg;
    assign result.m00       = m_reg[0];
    assign result.m01       = m_reg[1];
    assign result.m02       = m_reg[2];
    assign result.m10       = m_reg[3];
    assign result.m11       = m_reg[4];
    assign result.m12       = m_reg[5];
    assign result.m20       = m_reg[6];
    assign result.m21       = m_reg[7];
    assign result.m22       = m_reg[8];
    assign result.axis_zero = zero_reg;

    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && !result.ready) |-> !item.ready)
        else $error("input taken while output stalled");

    a_transfer_enters: assert property (@(posedge clk) disable iff (!rst_n)
        (item.valid && item.ready) |=> vld_reg[0])
        else $error("input transfer lost at pipeline entry");

    a_identity_on_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.axis_zero) |->
        (result.m00 == aarm_pkg::ENT_W'(aarm_pkg::ENT_ONE) && result.m01 == '0
         && result.m11 == aarm_pkg::ENT_W'(aarm_pkg::ENT_ONE) && result.m21 == '0))
        else $error("zero axis without identity matrix");

    a_entry_range: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |->
        (result.m00 <= aarm_pkg::ENT_W'(aarm_pkg::ENT_ONE)
         && result.m00 >= -aarm_pkg::ENT_W'(aarm_pkg::ENT_ONE)
         && result.m12 <= aarm_pkg::ENT_W'(aarm_pkg::ENT_ONE)
         && result.m12 >= -aarm_pkg::ENT_W'(aarm_pkg::ENT_ONE)))
        else $error("matrix entry beyond unit range");

endmodule

`default_nettype wire

### dv/testbench.sv
// Testbench for the axis-angle rotation matrix block: directed table, then random items.
`timescale 1ns / 100ps
`default_nettype none

module testbench;

    typedef struct {
        logic signed [aarm_pkg::ANGLE_W-1:0] angle;
        logic signed [aarm_pkg::AXIS_W-1:0]  ax;
        logic signed [aarm_pkg::AXIS_W-1:0]  ay;
        logic signed [aarm_pkg::AXIS_W-1:0]  az;
    } rot_req_t;

    typedef struct {
        logic signed [aarm_pkg::ENT_W-1:0] m [9];
        logic                              zero;
    } rot_mat_t;

    typedef struct {
        rot_req_t req;
        logic     known;
        rot_mat_t mat;
    } stim_row_t;

    localparam logic signed [aarm_pkg::ENT_W-1:0] E1 = aarm_pkg::ENT_W'(aarm_pkg::ENT_ONE);
    localparam logic signed [aarm_pkg::ENT_W-1:0] EM = -aarm_pkg::ENT_W'(aarm_pkg::ENT_ONE);

    logic clk;
    logic rst_n;
    aarm_in_if  item ();
    aarm_out_if result ();

    axis_angle_rotation_matrix dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item.sink),
        .result (result.source)
    );

    rot_mat_t  matrix_queue [$];
    int        errors;
    bit        idle_off;
    bit        hold_long;
    stim_row_t dir_rows [$];

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #20ms;
        $display("Some tests failed");
        $finish;
    end

    function automatic longint floor_shr(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint q30_mul(longint a, longint b);
        return floor_shr(a * b, 30);
    endfunction

    function automatic logic signed [aarm_pkg::ENT_W-1:0] round_entry(longint v);
        longint e;
        e = floor_shr(v + 8192, 14);
        if (e > aarm_pkg::ENT_ONE) e = aarm_pkg::ENT_ONE;
        if (e < -aarm_pkg::ENT_ONE) e = -aarm_pkg::ENT_ONE;
        return aarm_pkg::ENT_W'(e);
    endfunction

    function automatic longint unit_part(longint v, longint unsigned root);
        longint unsigned mag;
        longint unsigned u;
        mag = (v < 0) ? -v : v;
        u = (mag << 46) / root;
        if (u > aarm_pkg::ONE_Q30) u = aarm_pkg::ONE_Q30;
        return (v < 0) ? -longint'(u) : longint'(u);
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned n);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > n) b = b >> 2;
        while (b != 0)
        begin
            if (n >= res + b)
            begin
                n = n - (res + b);
                res = (res >> 1) + b;
            end
            else
                res = res >> 1;
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic rot_mat_t rotation_of(rot_req_t r);
        rot_mat_t        o;
        longint          ang, ax, ay, az, red, x, y, z, dx, dy, c, s, t;
        longint          ux, uy, uz, xy, xz, yz;
        longint unsigned len2, root;
        aarm_pkg::quad_t quad;
        ang = r.angle;
        ax = r.ax;
        ay = r.ay;
        az = r.az;
        len2 = ax * ax + ay * ay + az * az;
        if (len2 == 0)
        begin
            for (int i = 0; i < 9; i++) o.m[i] = (i % 4 == 0) ? E1 : '0;
            o.zero = 1'b1;
            return o;
        end
        red = ang % aarm_pkg::FULL_TURN;
        if (red < 0) red += aarm_pkg::FULL_TURN;
        quad = aarm_pkg::quad_t'(red / aarm_pkg::QUARTER_TURN);
        z = (red % aarm_pkg::QUARTER_TURN) * 32768;
        x = aarm_pkg::CORDIC_X0;
        y = 0;
        for (int i = 0; i < aarm_pkg::CORDIC_STEPS; i++)
        begin
            dx = floor_shr(y, i);
            dy = floor_shr(x, i);
            if (z >= 0)
            begin
                x -= dx; y += dy; z -= longint'(aarm_pkg::ATAN_TAB[i]);
            end
            else
            begin
                x += dx; y -= dy; z += longint'(aarm_pkg::ATAN_TAB[i]);
            end
        end
        case (quad)
            aarm_pkg::QUAD_0: begin c = x;  s = y;  end
            aarm_pkg::QUAD_1: begin c = -y; s = x;  end
            aarm_pkg::QUAD_2: begin c = -x; s = -y; end
            default:          begin c = y;  s = -x; end
        endcase
        root = int_sqrt(len2 << 32);
        ux = unit_part(ax, root);
        uy = unit_part(ay, root);
        uz = unit_part(az, root);
        t = aarm_pkg::ONE_Q30 - c;
        xy = q30_mul(q30_mul(ux, uy), t);
        xz = q30_mul(q30_mul(ux, uz), t);
        yz = q30_mul(q30_mul(uy, uz), t);
        o.m[0] = round_entry(c + q30_mul(q30_mul(ux, ux), t));
        o.m[1] = round_entry(xy - q30_mul(uz, s));
        o.m[2] = round_entry(xz + q30_mul(uy, s));
        o.m[3] = round_entry(xy + q30_mul(uz, s));
        o.m[4] = round_entry(c + q30_mul(q30_mul(uy, uy), t));
        o.m[5] = round_entry(yz - q30_mul(ux, s));
        o.m[6] = round_entry(xz - q30_mul(uy, s));
        o.m[7] = round_entry(yz + q30_mul(ux, s));
        o.m[8] = round_entry(c + q30_mul(q30_mul(uz, uz), t));
        o.zero = 1'b0;
        return o;
    endfunction

    function automatic bit mats_differ(rot_mat_t a, rot_mat_t b);
        bit d;
        d = (a.zero !== b.zero);
        for (int i = 0; i < 9; i++)
            if (a.m[i] !== b.m[i]) d = 1'b1;
        return d;
    endfunction

    function automatic void add_row(int ang, int x, int y, int z, bit known,
                                    rot_mat_t m);
        stim_row_t row;
        row.req.angle = aarm_pkg::ANGLE_W'(ang);
        row.req.ax = aarm_pkg::AXIS_W'(x);
        row.req.ay = aarm_pkg::AXIS_W'(y);
        row.req.az = aarm_pkg::AXIS_W'(z);
        row.known = known;
        row.mat = m;
        dir_rows.push_back(row);
    endfunction

    function automatic rot_mat_t diag_mat(logic signed [aarm_pkg::ENT_W-1:0] a,
                                          logic signed [aarm_pkg::ENT_W-1:0] b,
                                          logic signed [aarm_pkg::ENT_W-1:0] d);
        rot_mat_t m;
        for (int i = 0; i < 9; i++) m.m[i] = '0;
        m.m[0] = a;
        m.m[4] = b;
        m.m[8] = d;
        m.zero = 1'b0;
        return m;
    endfunction

    function automatic rot_mat_t zero_axis_mat();
        rot_mat_t m;
        m = diag_mat(E1, E1, E1);
        m.zero = 1'b1;
        return m;
    endfunction

    task automatic send_item(rot_req_t r);
        item.valid     <= 1'b1;
        item.angle_deg <= r.angle;
        item.axis_x    <= r.ax;
        item.axis_y    <= r.ay;
        item.axis_z    <= r.az;
        do @(posedge clk); while (!item.ready);
        matrix_queue.push_back(rotation_of(r));
        if (!idle_off && $urandom_range(0, 3) == 0)
        begin
            item.valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
    endtask

    function automatic logic signed [aarm_pkg::AXIS_W-1:0] rand_axis();
        case ($urandom_range(0, 5))
            0: return aarm_pkg::AXIS_W'($urandom_range(0, 7)) - 16'sd3;
            1: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
            default: return aarm_pkg::AXIS_W'($urandom);
        endcase
    endfunction

    task automatic send_random(int count);
        rot_req_t r;
        for (int n = 0; n < count; n++)
        begin
            case ($urandom_range(0, 3))
                0: r.angle = aarm_pkg::ANGLE_W'($urandom_range(0, 4) * aarm_pkg::QUARTER_TURN
                                                + $urandom_range(0, 4))
                             - aarm_pkg::ANGLE_W'(2);
                1: r.angle = aarm_pkg::ANGLE_W'($urandom_range(0, aarm_pkg::FULL_TURN - 1));
                default: r.angle = aarm_pkg::ANGLE_W'($urandom);
            endcase
            r.ax = rand_axis();
            r.ay = rand_axis();
            r.az = rand_axis();
            if ($urandom_range(0, 40) == 0)
            begin
                r.ax = '0; r.ay = '0; r.az = '0;
            end
            send_item(r);
        end
    endtask

    task automatic wait_drained();
        item.valid <= 1'b0;
        while (matrix_queue.size() != 0) @(posedge clk);
    endtask

    // Sink: check each transfer against the oldest expected matrix
    initial
    begin
        rot_mat_t want;
        logic signed [aarm_pkg::ENT_W-1:0] got [9];
        result.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (result.valid && result.ready)
            begin
                got = '{result.m00, result.m01, result.m02, result.m10, result.m11,
                        result.m12, result.m20, result.m21, result.m22};
                if (matrix_queue.size() == 0)
                begin
                    $error("unexpected result transfer");
                    errors++;
                end
                else
                begin
                    want = matrix_queue.pop_front();
                    for (int i = 0; i < 9; i++)
                        if (got[i] !== want.m[i])
                        begin
                            $error("m%0d%0d: expected %0d, got %0d", i / 3, i % 3,
                                   want.m[i], got[i]);
                            errors++;
                        end
                    if (result.axis_zero !== want.zero)
                    begin
                        $error("axis_zero: expected %0d, got %0d", want.zero,
                               result.axis_zero);
                        errors++;
                    end
                end
            end
            if (hold_long)
                result.ready <= 1'b0;
            else if (idle_off)
                result.ready <= 1'b1;
            else if ($urandom_range(0, 5) == 0)
            begin
                result.ready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge clk);
                result.ready <= 1'b1;
            end
            else
                result.ready <= 1'b1;
        end
    end

    // Long receiver hold-off so the pipeline fills and stalls its input
    initial
    begin
        hold_long = 1'b0;
        @(posedge rst_n);
        repeat (3000) @(posedge clk);
        hold_long <= 1'b1;
        repeat (200) @(posedge clk);
        hold_long <= 1'b0;
    end

    initial
    begin
        rot_mat_t none;
        errors = 0;
        idle_off = 1'b0;
        rst_n = 1'b0;
        item.valid = 1'b0;
        item.angle_deg = '0;
        item.axis_x = '0;
        item.axis_y = '0;
        item.axis_z = '0;
        none = zero_axis_mat();

        add_row(0, 0, 0, 0, 1, zero_axis_mat());
        add_row(8388607, 0, 0, 0, 1, zero_axis_mat());
        add_row(0, 1, 0, 0, 1, diag_mat(E1, E1, E1));
        add_row(0, 0, 0, -32768, 1, diag_mat(E1, E1, E1));
        add_row(aarm_pkg::FULL_TURN, 0, 32767, 0, 1, diag_mat(E1, E1, E1));
        add_row(2 * aarm_pkg::QUARTER_TURN, 0, 0, 5, 1, diag_mat(EM, EM, E1));
        add_row(2 * aarm_pkg::QUARTER_TURN, 7, 0, 0, 1, diag_mat(E1, EM, EM));
        add_row(aarm_pkg::QUARTER_TURN, 0, 0, 1, 0, none);
        add_row(3 * aarm_pkg::QUARTER_TURN, 0, 1, 0, 0, none);
        add_row(-aarm_pkg::QUARTER_TURN, 1, 0, 0, 0, none);
        add_row(-8388608, 32767, 32767, 32767, 0, none);
        add_row(8388607, -32768, -32768, -32768, 0, none);
        add_row(-1, -32768, 32767, 1, 0, none);
        add_row(1, 1, 1, 1, 0, none);
        add_row(aarm_pkg::FULL_TURN - 1, 3, -4, 12, 0, none);
        add_row(aarm_pkg::QUARTER_TURN - 1, -1, 0, 0, 0, none);
        add_row(aarm_pkg::QUARTER_TURN + 1, 0, -1, 0, 0, none);
        add_row(5760, 100, 200, -300, 0, none);
        add_row(-5760, -32768, 0, 0, 0, none);

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[k])
        begin
            if (dir_rows[k].known && mats_differ(rotation_of(dir_rows[k].req),
                                                 dir_rows[k].mat))
            begin
                $error("row %0d: table and predictor disagree", k);
                errors++;
            end
            send_item(dir_rows[k].req);
        end

        send_random(1300);
        // Hold the sender until the pipeline drains completely
        wait_drained();
        send_random(300);
        idle_off = 1'b1;
        send_random(300);
        wait_drained();
        repeat (40) @(posedge clk);

        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule

`default_nettype wire
